// ===== rtl/assert_macros.svh =====
// assertion macros shared by the composer rtl
// expects clk and rst (synchronous, active high) in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/a2tc_pkg.sv =====
// shared types, codes and micro-program tables of the affine composer
// no dependencies
package a2tc_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int FRAC_W       = 16;
  localparam int RND_W        = ACC_W - FRAC_W;
  localparam int IDX_W        = 4;
  localparam int COMP_STEPS   = 12;
  localparam int DRAIN_CYCLES = 2;

  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd65536;
  localparam logic signed [DATA_W-1:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] MIN_Q = 32'sh80000000;

  localparam logic [OP_W-1:0] OP_GENERAL   = 3'd0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd1;
  localparam logic [OP_W-1:0] OP_SCALE     = 3'd2;
  localparam logic [OP_W-1:0] OP_ROTATE    = 3'd3;
  localparam logic [OP_W-1:0] OP_REFLECT   = 3'd4;
  localparam logic [OP_W-1:0] OP_SHEAR     = 3'd5;

  // multiplier operand sources: latched args, current matrix, elementary matrix
  typedef enum logic [3:0] {
    SRC_A, SRC_B, SRC_C, SRC_D,
    SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5,
    SRC_E0, SRC_E1, SRC_E2, SRC_E3
  } src_t;

  // constant term that seeds an entry's accumulator
  typedef enum logic [1:0] {
    K_ZERO, K_ONE, K_TX, K_TY
  } ksel_t;

  // where a finished entry goes
  typedef enum logic [3:0] {
    DST_E0, DST_E1, DST_E2, DST_E3,
    DST_E12,   // reflect: xy and yx are equal
    DST_SIN,   // rotate: xy = s, yx = -s
    DST_N0, DST_N1, DST_N2, DST_N3, DST_N4, DST_N5,
    DST_COS    // rotate: xx and yy are both c
  } dst_t;

  typedef struct packed {
    src_t  x;
    src_t  y;
    logic  neg;
    logic  dbl;
    logic  first;
    logic  last;
    ksel_t k;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    uop_t uop;
    logic commit;
    logic use_el;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ELEM, ST_ELEM_WAIT, ST_COMP, ST_COMP_WAIT, ST_FINISH
  } state_t;

  function automatic uop_t mk_uop(src_t x, src_t y, logic neg, logic dbl,
                                  logic first, logic last, ksel_t k, dst_t dst);
    uop_t u;
    u.x     = x;
    u.y     = y;
    u.neg   = neg;
    u.dbl   = dbl;
    u.first = first;
    u.last  = last;
    u.k     = k;
    u.dst   = dst;
    return u;
  endfunction

  // number of products needed to build the elementary matrix
  function automatic logic [IDX_W-1:0] elem_len(logic [OP_W-1:0] op);
    logic [IDX_W-1:0] n;
    case (op)
      OP_ROTATE:  n = 4'd4;
      OP_REFLECT: n = 4'd3;
      OP_SHEAR:   n = 4'd2;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic uop_t elem_uop(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    uop_t u;
    u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
    case (op)
      OP_ROTATE: begin
        case (idx)
          4'd0:    u = mk_uop(SRC_A, SRC_C, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_COS);
          4'd1:    u = mk_uop(SRC_B, SRC_D, 1'b0, 1'b0, 1'b0, 1'b1, K_ZERO, DST_COS);
          4'd2:    u = mk_uop(SRC_B, SRC_C, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_SIN);
          4'd3:    u = mk_uop(SRC_A, SRC_D, 1'b1, 1'b0, 1'b0, 1'b1, K_ZERO, DST_SIN);
          default: u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
        endcase
      end
      OP_REFLECT: begin
        case (idx)
          4'd0:    u = mk_uop(SRC_A, SRC_A, 1'b1, 1'b1, 1'b1, 1'b1, K_ONE, DST_E0);
          4'd1:    u = mk_uop(SRC_A, SRC_B, 1'b1, 1'b1, 1'b1, 1'b1, K_ZERO, DST_E12);
          4'd2:    u = mk_uop(SRC_B, SRC_B, 1'b1, 1'b1, 1'b1, 1'b1, K_ONE, DST_E3);
          default: u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
        endcase
      end
      OP_SHEAR: begin
        case (idx)
          4'd0:    u = mk_uop(SRC_C, SRC_A, 1'b0, 1'b0, 1'b1, 1'b1, K_ZERO, DST_E1);
          4'd1:    u = mk_uop(SRC_C, SRC_B, 1'b0, 1'b0, 1'b1, 1'b1, K_ZERO, DST_E2);
          default: u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
        endcase
      end
      default: u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
    endcase
    return u;
  endfunction

  // new = m * e, two products per entry, row-vector convention
  function automatic uop_t comp_uop(logic [IDX_W-1:0] idx);
    uop_t u;
    case (idx)
      4'd0:    u = mk_uop(SRC_M0, SRC_E0, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_N0);
      4'd1:    u = mk_uop(SRC_M1, SRC_E2, 1'b0, 1'b0, 1'b0, 1'b1, K_ZERO, DST_N0);
      4'd2:    u = mk_uop(SRC_M0, SRC_E1, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_N1);
      4'd3:    u = mk_uop(SRC_M1, SRC_E3, 1'b0, 1'b0, 1'b0, 1'b1, K_ZERO, DST_N1);
      4'd4:    u = mk_uop(SRC_M2, SRC_E0, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_N2);
      4'd5:    u = mk_uop(SRC_M3, SRC_E2, 1'b0, 1'b0, 1'b0, 1'b1, K_ZERO, DST_N2);
      4'd6:    u = mk_uop(SRC_M2, SRC_E1, 1'b0, 1'b0, 1'b1, 1'b0, K_ZERO, DST_N3);
      4'd7:    u = mk_uop(SRC_M3, SRC_E3, 1'b0, 1'b0, 1'b0, 1'b1, K_ZERO, DST_N3);
      4'd8:    u = mk_uop(SRC_M4, SRC_E0, 1'b0, 1'b0, 1'b1, 1'b0, K_TX, DST_N4);
      4'd9:    u = mk_uop(SRC_M5, SRC_E2, 1'b0, 1'b0, 1'b0, 1'b1, K_TX, DST_N4);
      4'd10:   u = mk_uop(SRC_M4, SRC_E1, 1'b0, 1'b0, 1'b1, 1'b0, K_TY, DST_N5);
      4'd11:   u = mk_uop(SRC_M5, SRC_E3, 1'b0, 1'b0, 1'b0, 1'b1, K_TY, DST_N5);
      default: u = mk_uop(SRC_A, SRC_A, 1'b0, 1'b0, 1'b0, 1'b0, K_ZERO, DST_E0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/affine_2d_transform_composer.sv =====
// top level of the running 2d affine matrix composer
// depends on a2tc_pkg, a2tc_ctrl and a2tc_dp
//
// holds a 2x3 affine matrix (xx xy / yx yy / tx ty) in signed q16.16, identity
// after reset. each input item selects an elementary matrix e (general, translate,
// scale, rotate by a vector pair, reflect about a normal, shear; codes 6 and 7
// mean identity). with replace set the matrix becomes e, otherwise m*e in
// row-vector form. every computed entry is an exact sum of 64-bit products,
// rounded half up at bit 16 and clamped to 32 bits; saturated reports any clamp
// in e or in the new matrix. one result item (the six new entries) per input
// item. all products run through one registered 32x32 multiplier feeding a
// 66-bit accumulator, three stages deep. per item the sequencer issues the
// products of e, if any (4 for rotate, 3 for reflect, 2 for shear), lets them
// drain, and unless replace is set issues the 12 products of m*e and lets them
// drain too; it then registers the result once the output slot is free. the
// next item is accepted as soon as the previous result is registered, even
// while out_stall holds it.
module affine_2d_transform_composer import a2tc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          op,
  input  logic                     replace,
  input  logic signed [DATA_W-1:0] arg_a,
  input  logic signed [DATA_W-1:0] arg_b,
  input  logic signed [DATA_W-1:0] arg_c,
  input  logic signed [DATA_W-1:0] arg_d,
  input  logic signed [DATA_W-1:0] arg_e,
  input  logic signed [DATA_W-1:0] arg_f,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_xx,
  output logic signed [DATA_W-1:0] out_xy,
  output logic signed [DATA_W-1:0] out_yx,
  output logic signed [DATA_W-1:0] out_yy,
  output logic signed [DATA_W-1:0] out_tx,
  output logic signed [DATA_W-1:0] out_ty,
  output logic                     saturated
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks the micro-program for the latched op, then composition unless replace is set
  a2tc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .replace  (replace),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: operand latches, multiplier, accumulator, matrix and result regs
  a2tc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .arg_a     (arg_a),
    .arg_b     (arg_b),
    .arg_c     (arg_c),
    .arg_d     (arg_d),
    .arg_e     (arg_e),
    .arg_f     (arg_f),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_xx    (out_xx),
    .out_xy    (out_xy),
    .out_yx    (out_yx),
    .out_yy    (out_yy),
    .out_tx    (out_tx),
    .out_ty    (out_ty),
    .saturated (saturated)
  );

endmodule

// ===== rtl/a2tc_dp.sv =====
// datapath: shared multiplier, accumulator, rounding, matrix and output registers
// depends on a2tc_pkg and assert_macros.svh
`include "assert_macros.svh"

module a2tc_dp import a2tc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] arg_a,
  input  logic signed [DATA_W-1:0] arg_b,
  input  logic signed [DATA_W-1:0] arg_c,
  input  logic signed [DATA_W-1:0] arg_d,
  input  logic signed [DATA_W-1:0] arg_e,
  input  logic signed [DATA_W-1:0] arg_f,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_xx,
  output logic signed [DATA_W-1:0] out_xy,
  output logic signed [DATA_W-1:0] out_yx,
  output logic signed [DATA_W-1:0] out_yy,
  output logic signed [DATA_W-1:0] out_tx,
  output logic signed [DATA_W-1:0] out_ty,
  output logic                     saturated
);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

  logic signed [DATA_W-1:0] a_q, b_q, c_q, d_q;
  logic signed [DATA_W-1:0] el [6];
  logic signed [DATA_W-1:0] m  [6];
  logic signed [DATA_W-1:0] nm [6];
  logic signed [DATA_W-1:0] el_init [6];
  logic signed [DATA_W-1:0] cm [6];

  logic signed [DATA_W-1:0] x_op, y_op;
  logic signed [PROD_W-1:0] prod_next, prod;

  logic        s1_v, s1_neg, s1_dbl, s1_first, s1_last;
  ksel_t       s1_k;
  dst_t        s1_dst;
  logic        s2_last;
  dst_t        s2_dst;

  logic signed [ACC_W-1:0]  acc, acc_next, term_one, term, addend, base, rsum;
  logic signed [DATA_W-1:0] kval;
  logic signed [RND_W-1:0]  rnd;
  logic                     ovf_hi, ovf_lo, res_sat, neg_sat;
  logic signed [DATA_W-1:0] res, neg_res;
  logic                     sat_acc;

  // operand select
  always_comb begin
    case (cmd.uop.x)
      SRC_A:   x_op = a_q;
      SRC_B:   x_op = b_q;
      SRC_C:   x_op = c_q;
      SRC_D:   x_op = d_q;
      SRC_M0:  x_op = m[0];
      SRC_M1:  x_op = m[1];
      SRC_M2:  x_op = m[2];
      SRC_M3:  x_op = m[3];
      SRC_M4:  x_op = m[4];
      SRC_M5:  x_op = m[5];
      default: x_op = a_q;
    endcase
    case (cmd.uop.y)
      SRC_A:   y_op = a_q;
      SRC_B:   y_op = b_q;
      SRC_C:   y_op = c_q;
      SRC_D:   y_op = d_q;
      SRC_E0:  y_op = el[0];
      SRC_E1:  y_op = el[1];
      SRC_E2:  y_op = el[2];
      SRC_E3:  y_op = el[3];
      default: y_op = a_q;
    endcase
  end

  assign prod_next = x_op * y_op;

  // accumulate stage
  always_comb begin
    case (s1_k)
      K_ONE:   kval = ONE_Q;
      K_TX:    kval = el[4];
      K_TY:    kval = el[5];
      default: kval = '0;
    endcase
    term_one = ACC_W'(prod);
    term     = s1_dbl ? (term_one <<< 1) : term_one;
    addend   = s1_neg ? -term : term;
    base     = s1_first ? (ACC_W'(kval) <<< FRAC_W) : acc;
    acc_next = base + addend;
  end

  // round half up, then clamp to 32 bits
  always_comb begin
    rsum    = acc + RND_HALF;
    rnd     = rsum[ACC_W-1:FRAC_W];
    ovf_hi  = !rnd[RND_W-1] && (|rnd[RND_W-2:DATA_W-1]);
    ovf_lo  = rnd[RND_W-1] && !(&rnd[RND_W-2:DATA_W-1]);
    res_sat = ovf_hi || ovf_lo;
    if (ovf_hi) begin
      res = MAX_Q;
    end else if (ovf_lo) begin
      res = MIN_Q;
    end else begin
      res = rnd[DATA_W-1:0];
    end
    neg_sat = (res == MIN_Q);
    neg_res = neg_sat ? MAX_Q : -res;
  end

  // elementary matrix straight from the operands
  always_comb begin
    el_init[0] = ONE_Q;
    el_init[1] = '0;
    el_init[2] = '0;
    el_init[3] = ONE_Q;
    el_init[4] = '0;
    el_init[5] = '0;
    case (op)
      OP_GENERAL: begin
        el_init[0] = arg_a;
        el_init[1] = arg_b;
        el_init[2] = arg_c;
        el_init[3] = arg_d;
        el_init[4] = arg_e;
        el_init[5] = arg_f;
      end
      OP_TRANSLATE: begin
        el_init[4] = arg_a;
        el_init[5] = arg_b;
      end
      OP_SCALE: begin
        el_init[0] = arg_a;
        el_init[3] = arg_b;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      cm[i] = cmd.use_el ? el[i] : nm[i];
    end
  end

  assign stat.slot_free = !out_valid || !out_stall;

  // control and matrix state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_last   <= 1'b0;
      out_valid <= 1'b0;
      sat_acc   <= 1'b0;
      m[0]      <= ONE_Q;
      m[1]      <= '0;
      m[2]      <= '0;
      m[3]      <= ONE_Q;
      m[4]      <= '0;
      m[5]      <= '0;
    end else begin
      s1_v    <= cmd.issue;
      s2_last <= s1_v && s1_last;
      if (cmd.load) begin
        sat_acc <= 1'b0;
      end else if (s2_last && (res_sat || ((s2_dst == DST_SIN) && neg_sat))) begin
        sat_acc <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        for (int i = 0; i < 6; i++) begin
          m[i] <= cm[i];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod     <= prod_next;
    s1_neg   <= cmd.uop.neg;
    s1_dbl   <= cmd.uop.dbl;
    s1_first <= cmd.uop.first;
    s1_last  <= cmd.uop.last;
    s1_k     <= cmd.uop.k;
    s1_dst   <= cmd.uop.dst;
    s2_dst   <= s1_dst;
    if (s1_v) begin
      acc <= acc_next;
    end
    if (cmd.load) begin
      a_q <= arg_a;
      b_q <= arg_b;
      c_q <= arg_c;
      d_q <= arg_d;
      for (int i = 0; i < 6; i++) begin
        el[i] <= el_init[i];
      end
    end else if (s2_last) begin
      case (s2_dst)
        DST_E0:  el[0] <= res;
        DST_E1:  el[1] <= res;
        DST_E2:  el[2] <= res;
        DST_E3:  el[3] <= res;
        DST_E12: begin
          el[1] <= res;
          el[2] <= res;
        end
        DST_SIN: begin
          el[1] <= res;
          el[2] <= neg_res;
        end
        DST_COS: begin
          el[0] <= res;
          el[3] <= res;
        end
        DST_N0:  nm[0] <= res;
        DST_N1:  nm[1] <= res;
        DST_N2:  nm[2] <= res;
        DST_N3:  nm[3] <= res;
        DST_N4:  nm[4] <= res;
        DST_N5:  nm[5] <= res;
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      out_xx    <= cm[0];
      out_xy    <= cm[1];
      out_yx    <= cm[2];
      out_yy    <= cm[3];
      out_tx    <= cm[4];
      out_ty    <= cm[5];
      saturated <= sat_acc;
    end
  end

  `ASSERT_IMPL(a_commit_drained, cmd.commit, !s1_v && !s2_last, "commit with products in flight")
  `ASSERT_IMPL(a_load_drained, cmd.load, !s1_v && !s2_last && !cmd.issue, "load during compute")
  `ASSERT_IMPL(a_out_from_commit, $rose(out_valid), $past(cmd.commit), "result without commit")

endmodule

// ===== rtl/a2tc_ctrl.sv =====
// controller: sequences the elementary-matrix and composition micro-programs
// depends on a2tc_pkg and assert_macros.svh
`include "assert_macros.svh"

module a2tc_ctrl import a2tc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] op,
  input  logic            replace,
  input  stat_t           stat,
  output cmd_t            cmd
);

  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] COMP_LAST = IDX_W'(COMP_STEPS - 1);
  localparam logic [IDX_W-1:0] WAIT_LAST = IDX_W'(DRAIN_CYCLES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [OP_W-1:0]  op_q;
  logic             rep_q;
  logic             accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (elem_len(op) != '0) begin
            state_next = ST_ELEM;
          end else if (replace) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_COMP;
          end
        end
      end
      ST_ELEM: begin
        if (idx + IDX_ONE == elem_len(op_q)) state_next = ST_ELEM_WAIT;
      end
      ST_ELEM_WAIT: begin
        if (idx == WAIT_LAST) state_next = rep_q ? ST_FINISH : ST_COMP;
      end
      ST_COMP: begin
        if (idx == COMP_LAST) state_next = ST_COMP_WAIT;
      end
      ST_COMP_WAIT: begin
        if (idx == WAIT_LAST) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // step counter restarts on every state change
  always_comb begin
    if (state_next != state) begin
      idx_next = '0;
    end else begin
      idx_next = idx + IDX_ONE;
    end
  end

  always_comb begin
    in_stall   = (state != ST_IDLE);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.issue  = (state == ST_ELEM) || (state == ST_COMP);
    cmd.uop    = (state == ST_ELEM) ? elem_uop(op_q, idx) : comp_uop(idx);
    cmd.commit = (state == ST_FINISH) && stat.slot_free;
    cmd.use_el = rep_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      op_q  <= '0;
      rep_q <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept) begin
        op_q  <= op;
        rep_q <= replace;
      end
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "item accepted but not busy")

endmodule

// ===== test/affine_2d_transform_composer_test.sv =====
// self-checking bench for the running 2d affine matrix composer
// needs a2tc_pkg and affine_2d_transform_composer; mirrors the q16.16 matrix
// in the bench and checks every result item against that copy
`timescale 1ns / 100ps

module affine_2d_transform_composer_test;
  import a2tc_pkg::*;

  // codes 6 and 7 have no name in the package; both act as identity
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_PCT     = 13;
  localparam int DRAIN_WAIT   = 40;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic                     rep;
    logic signed [DATA_W-1:0] a, b, c, d, e, f;
  } op_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] xx, xy, yx, yy, tx, ty;
    logic                     sat;
  } matrix_out_t;

  logic clk;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          op       = '0;
  logic                     replace  = 1'b0;
  logic signed [DATA_W-1:0] arg_a    = '0;
  logic signed [DATA_W-1:0] arg_b    = '0;
  logic signed [DATA_W-1:0] arg_c    = '0;
  logic signed [DATA_W-1:0] arg_d    = '0;
  logic signed [DATA_W-1:0] arg_e    = '0;
  logic signed [DATA_W-1:0] arg_f    = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_xx, out_xy, out_yx, out_yy, out_tx, out_ty;
  logic                     saturated;

  affine_2d_transform_composer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .replace   (replace),
    .arg_a     (arg_a),
    .arg_b     (arg_b),
    .arg_c     (arg_c),
    .arg_d     (arg_d),
    .arg_e     (arg_e),
    .arg_f     (arg_f),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_xx    (out_xx),
    .out_xy    (out_xy),
    .out_yx    (out_yx),
    .out_yy    (out_yy),
    .out_tx    (out_tx),
    .out_ty    (out_ty),
    .saturated (saturated)
  );

  // items waiting to be driven, and matrices waiting to come out
  op_item_t    pending_items[$];
  matrix_out_t matrix_expect_q[$];

  // bench copy of the running matrix: xx xy yx yy tx ty, identity after reset
  logic signed [DATA_W-1:0] cur_mat [6] = '{ONE_Q, 0, 0, ONE_Q, 0, 0};
  logic     step_clamped;
  op_item_t on_bus;

  int n_errors    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_sat_seen  = 0;
  int op_hits [8] = '{default: 0};

  // idling is switched off for a stretch in the middle of the random part
  function automatic bit quiet_window();
    return (n_accepted >= 400) && (n_accepted < 600);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // q16.16 arithmetic of the bench predictor
  // ---------------------------------------------------------------------------

  // full 64-bit product of two q16.16 values (a q32.32 number)
  function automatic logic signed [63:0] mul(input logic signed [DATA_W-1:0] x,
                                             input logic signed [DATA_W-1:0] y);
    logic signed [63:0] wx, wy;
    wx = x;
    wy = y;
    return wx * wy;
  endfunction

  // k (q16.16) plus two q32.32 products, rounded half up at bit 16, clamped;
  // any clamp marks the current step as saturated
  function automatic logic signed [DATA_W-1:0] fx_sum(input logic signed [DATA_W-1:0] k,
                                                      input logic signed [63:0] p1,
                                                      input logic signed [63:0] p2);
    logic signed [127:0] s, hi_lim, lo_lim;
    s      = k;
    s      = s <<< FRAC_W;
    s      = s + p1 + p2 + 128'sd32768;
    s      = s >>> FRAC_W;
    hi_lim = MAX_Q;
    lo_lim = MIN_Q;
    if (s > hi_lim) begin
      step_clamped = 1'b1;
      return MAX_Q;
    end
    if (s < lo_lim) begin
      step_clamped = 1'b1;
      return MIN_Q;
    end
    return s[DATA_W-1:0];
  endfunction

  // builds the elementary matrix for one item, loads or composes it onto the
  // bench matrix (row-vector form, m first then e) and queues the result
  task automatic apply_transform(input op_item_t it);
    logic signed [DATA_W-1:0] el [6];
    logic signed [DATA_W-1:0] nm [6];
    logic signed [DATA_W-1:0] co, si;
    matrix_out_t              res;
    el = '{ONE_Q, 0, 0, ONE_Q, 0, 0};
    step_clamped = 1'b0;
    case (it.op)
      OP_GENERAL: el = '{it.a, it.b, it.c, it.d, it.e, it.f};
      OP_TRANSLATE: begin
        el[4] = it.a;
        el[5] = it.b;
      end
      OP_SCALE: begin
        el[0] = it.a;
        el[3] = it.b;
      end
      OP_ROTATE: begin
        // cosine from the dot product, sine from the cross product
        co = fx_sum(0, mul(it.a, it.c), mul(it.b, it.d));
        si = fx_sum(0, mul(it.b, it.c), -mul(it.a, it.d));
        el[0] = co;
        el[1] = si;
        // negating the most negative sine cannot be represented
        if (si == MIN_Q) begin
          el[2] = MAX_Q;
          step_clamped = 1'b1;
        end else begin
          el[2] = -si;
        end
        el[3] = co;
      end
      OP_REFLECT: begin
        el[0] = fx_sum(ONE_Q, -mul(it.a, it.a), -mul(it.a, it.a));
        el[1] = fx_sum(0, -mul(it.a, it.b), -mul(it.a, it.b));
        el[2] = el[1];
        el[3] = fx_sum(ONE_Q, -mul(it.b, it.b), -mul(it.b, it.b));
      end
      OP_SHEAR: begin
        el[1] = fx_sum(0, mul(it.c, it.a), 0);
        el[2] = fx_sum(0, mul(it.c, it.b), 0);
      end
      default: ;  // spare codes keep the identity
    endcase

    if (it.rep) begin
      nm = el;
    end else begin
      nm[0] = fx_sum(0,     mul(cur_mat[0], el[0]), mul(cur_mat[1], el[2]));
      nm[1] = fx_sum(0,     mul(cur_mat[0], el[1]), mul(cur_mat[1], el[3]));
      nm[2] = fx_sum(0,     mul(cur_mat[2], el[0]), mul(cur_mat[3], el[2]));
      nm[3] = fx_sum(0,     mul(cur_mat[2], el[1]), mul(cur_mat[3], el[3]));
      nm[4] = fx_sum(el[4], mul(cur_mat[4], el[0]), mul(cur_mat[5], el[2]));
      nm[5] = fx_sum(el[5], mul(cur_mat[4], el[1]), mul(cur_mat[5], el[3]));
    end

    cur_mat = nm;
    res.xx  = nm[0];
    res.xy  = nm[1];
    res.yx  = nm[2];
    res.yy  = nm[3];
    res.tx  = nm[4];
    res.ty  = nm[5];
    res.sat = step_clamped;
    matrix_expect_q.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [OP_W-1:0] o, input logic r,
                           input logic signed [DATA_W-1:0] a, b, c, d, e, f);
    op_item_t it;
    it.op  = o;
    it.rep = r;
    it.a   = a;
    it.b   = b;
    it.c   = c;
    it.d   = d;
    it.e   = e;
    it.f   = f;
    pending_items.push_back(it);
  endtask

  // operand mix: mostly moderate values so that compositions stay in range,
  // some sub-unit fractions, full-range noise and the corner values
  function automatic logic signed [DATA_W-1:0] rand_q();
    logic signed [DATA_W-1:0] v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      v = $urandom_range(0, 393216);
      v = v - 32'sd196608;
    end else if (sel < 70) begin
      v = $urandom_range(0, 131071);
      v = v - 32'sd65536;
    end else if (sel < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(7))
        0:       v = 0;
        1:       v = 1;
        2:       v = -1;
        3:       v = ONE_Q;
        4:       v = -ONE_Q;
        5:       v = MAX_Q;
        6:       v = MIN_Q;
        default: v = 32'sd32768;
      endcase
    end
    return v;
  endfunction

  // exact or near unit-vector components for rotate and reflect
  function automatic logic signed [DATA_W-1:0] unit_comp();
    case ($urandom_range(4))
      0:       return ONE_Q;
      1:       return -ONE_Q;
      2:       return 32'sd46341;
      3:       return -32'sd46341;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents pending items; the payload holds while in_stall is high
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_transform(on_bus);
        op_hits[on_bus.op] = op_hits[on_bus.op] + 1;
        n_accepted = n_accepted + 1;
      end
      // the bus is free when nothing is shown or the shown item just went in
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 &&
            (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_items.pop_front();
          op       <= on_bus.op;
          replace  <= on_bus.rep;
          arg_a    <= on_bus.a;
          arg_b    <= on_bus.b;
          arg_c    <= on_bus.c;
          arg_d    <= on_bus.d;
          arg_e    <= on_bus.e;
          arg_f    <= on_bus.f;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each result checked against the oldest
  // expected matrix
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors = n_errors + 1;
    end
  endtask

  always @(posedge clk) begin
    matrix_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (matrix_expect_q.size() == 0) begin
          $error("result item with no expected matrix pending");
          n_errors = n_errors + 1;
        end else begin
          want = matrix_expect_q.pop_front();
          check_field("out_xx", want.xx, out_xx);
          check_field("out_xy", want.xy, out_xy);
          check_field("out_yx", want.yx, out_yx);
          check_field("out_yy", want.yy, out_yy);
          check_field("out_tx", want.tx, out_tx);
          check_field("out_ty", want.ty, out_ty);
          check_field("saturated", {31'b0, want.sat}, {31'b0, saturated});
          n_results = n_results + 1;
          if (want.sat) n_sat_seen = n_sat_seen + 1;
        end
      end
      out_stall <= !quiet_window() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    op_item_t it;
    int       n_total;

    // directed part: corners of every op, rounding at exactly one half,
    // the sine that cannot be negated, spare codes with and without replace
    push_item(OP_GENERAL,   1'b1, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    push_item(OP_GENERAL,   1'b0, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    push_item(OP_GENERAL,   1'b1, 1, -1, ONE_Q, ONE_Q, 0, 0);
    // 1 * 0.5 rounds up to 1, -1 * 0.5 rounds up to 0
    push_item(OP_SCALE,     1'b0, 32'sd32768, 32'sd32768, 0, 0, 0, 0);
    push_item(OP_SPARE6,    1'b0, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
    push_item(OP_SPARE7,    1'b1, -1, -1, -1, -1, -1, -1);
    push_item(OP_TRANSLATE, 1'b0, MAX_Q, MIN_Q, 0, 0, 0, 0);
    push_item(OP_TRANSLATE, 1'b0, MAX_Q, MIN_Q, 0, 0, 0, 0);
    push_item(OP_SCALE,     1'b1, MIN_Q, MAX_Q, 0, 0, 0, 0);
    push_item(OP_ROTATE,    1'b1, ONE_Q, 0, 0, ONE_Q, 0, 0);
    push_item(OP_ROTATE,    1'b0, 32'sd46341, 32'sd46341, ONE_Q, 0, 0, 0);
    // sine comes out as the most negative value
    push_item(OP_ROTATE,    1'b1, 0, MIN_Q, ONE_Q, 0, 0, 0);
    push_item(OP_ROTATE,    1'b0, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 0, 0);
    push_item(OP_REFLECT,   1'b1, ONE_Q, 0, 0, 0, 0, 0);
    push_item(OP_REFLECT,   1'b0, 32'sd46341, 32'sd46341, 0, 0, 0, 0);
    push_item(OP_REFLECT,   1'b0, MIN_Q, MAX_Q, 0, 0, 0, 0);
    push_item(OP_SHEAR,     1'b0, ONE_Q, -ONE_Q, 32'sd32768, 0, 0, 0);
    push_item(OP_SHEAR,     1'b1, MAX_Q, MIN_Q, MAX_Q, 0, 0, 0);
    push_item(OP_SPARE7,    1'b0, 0, 0, 0, 0, 0, 0);
    push_item(OP_SPARE6,    1'b1, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q);
    push_item(OP_GENERAL,   1'b0, 0, 0, 0, 0, 0, 0);
    push_item(OP_GENERAL,   1'b1, -1, -1, -1, -1, MAX_Q, MIN_Q);

    // random part: long runs of compositions, broken up by loads so the
    // matrix does not stay pinned at the clamp limits
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it.op  = OP_W'($urandom_range(7));
      it.rep = ($urandom_range(99) < 15);
      it.a   = rand_q();
      it.b   = rand_q();
      it.c   = rand_q();
      it.d   = rand_q();
      it.e   = rand_q();
      it.f   = rand_q();
      if ((it.op == OP_ROTATE || it.op == OP_REFLECT) && $urandom_range(1)) begin
        it.a = unit_comp();
        it.b = unit_comp();
        it.c = unit_comp();
        it.d = unit_comp();
      end
      pending_items.push_back(it);
    end
    n_total = pending_items.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every item checked, then a wait for strays
    while (n_results < n_total) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d items, %0d results checked, %0d of them clamped",
             n_accepted, n_results, n_sat_seen);
    $display("per op code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", op_hits[0], op_hits[1],
             op_hits[2], op_hits[3], op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("timeout waiting for the composer");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/a2tc_pkg.sv
rtl/a2tc_dp.sv
rtl/a2tc_ctrl.sv
rtl/affine_2d_transform_composer.sv
test/affine_2d_transform_composer_test.sv
